/* hw/rtl/mbt_pkg.sv */
// ----------------------------------------------------------------------------
// mbt_pkg
// Shared widths, codes and types of the MAC binding table.
// ----------------------------------------------------------------------------
`default_nettype none

package mbt_pkg;

  localparam int unsigned EntriesDef = 16;

  localparam int unsigned KEY_W = 48;
  localparam int unsigned ID_W  = 16;
  localparam int unsigned LIM_W = 7;
  localparam int unsigned ACT_W = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP    = 3'd0,
    ACT_SET       = 3'd1,
    ACT_CLEAR     = 3'd2,
    ACT_CLEAR_ALL = 3'd3,
    ACT_LIST      = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/mbt_req_if.sv */
// ----------------------------------------------------------------------------
// mbt_req_if
// Request channel of the MAC binding table: one action per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbt_req_if
  import mbt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [KEY_W-1:0] mac_key;
  logic [ID_W-1:0]  new_id;
  logic [LIM_W-1:0] list_limit;

  modport source (output valid, action, mac_key, new_id, list_limit, input ready);
  modport sink   (input valid, action, mac_key, new_id, list_limit, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mbt_rsp_if.sv */
// ----------------------------------------------------------------------------
// mbt_rsp_if
// Response channel of the MAC binding table: one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbt_rsp_if
  import mbt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             ok;
  logic             entry_valid;
  logic [KEY_W-1:0] mac_out;
  logic [ID_W-1:0]  id_out;
  logic             last;

  modport source (output valid, ok, entry_valid, mac_out, id_out, last, input ready);
  modport sink   (input valid, ok, entry_valid, mac_out, id_out, last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mac_binding_table_top.sv */
// ----------------------------------------------------------------------------
// mac_binding_table_top
// Table binding 48-bit MAC keys to nonzero 16-bit ids, searched by a
// sequential scan through one key/id RAM.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req_i   | in  | action, mac_key, new_id, list_limit
//  rsp_o   | out | ok, entry_valid, mac_out, id_out, last
//
//  Lookup, set, clear: the scan walks the slots through the single RAM read
//  port, one slot per cycle; a hit ends the walk early. Clear all, set with a
//  zero id, list with zero limit and undefined actions skip the scan and go
//  straight to the result.
//  List: the scan restarts after each listed entry.
//  Of the table, reset clears only the used flags; RAM contents stay undefined.
//  req_i is ready only when idle; a held result stalls the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_binding_table_top
  import mbt_pkg::*;
#(
  parameter int unsigned Entries = EntriesDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mbt_req_if.sink   req_i,
  mbt_rsp_if.source rsp_o
);

  localparam int unsigned AW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned IW = $clog2(Entries + 1);
  localparam int unsigned DW = KEY_W + ID_W;

  state_e state_q, state_d;

  logic [ACT_W-1:0] act_q, act_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [ID_W-1:0]  nid_q, nid_d;
  logic [LIM_W-1:0] lim_q, lim_d;

  logic [IW-1:0]    idx_q, idx_d;
  logic             pv_q, pv_d;
  logic [AW-1:0]    pidx_q, pidx_d;
  logic [LIM_W-1:0] cnt_q, cnt_d;
  logic             free_vld_q, free_vld_d;
  logic [AW-1:0]    free_idx_q, free_idx_d;
  logic [Entries-1:0] used_q, used_d;

  logic             ok_q, ok_d;
  logic             ev_q, ev_d;
  logic [KEY_W-1:0] mac_q, mac_d;
  logic [ID_W-1:0]  idout_q, idout_d;
  logic             last_q, last_d;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr;
  logic [DW-1:0]    ram_rdata;
  logic [KEY_W-1:0] rd_key;
  logic [ID_W-1:0]  rd_id;

  logic             req_acc, direct, cur_used, hit, at_end, above, fin;
  logic [LIM_W-1:0] cnt_inc;

  mbt_ram #(
    .Width (DW),
    .Depth (Entries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({key_q, nid_q}),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_key = ram_rdata[DW-1:ID_W];
  assign rd_id  = ram_rdata[ID_W-1:0];

  assign req_i.ready       = (state_q == ST_IDLE);
  assign req_acc           = req_i.valid && req_i.ready;
  assign rsp_o.valid       = (state_q == ST_OUT);
  assign rsp_o.ok          = ok_q;
  assign rsp_o.entry_valid = ev_q;
  assign rsp_o.mac_out     = mac_q;
  assign rsp_o.id_out      = idout_q;
  assign rsp_o.last        = last_q;

  // scan events; RAM data of slot pidx_q is valid when pv_q
  always_comb begin
    cur_used = used_q[pidx_q];
    hit      = pv_q && cur_used && (rd_key == key_q);
    at_end   = pv_q && (pidx_q == AW'(Entries - 1));
    above    = ((used_q >> pidx_q) >> 1) != '0;
    cnt_inc  = cnt_q + LIM_W'(1);
    unique case (req_i.action)
      ACT_LOOKUP, ACT_CLEAR: direct = 1'b0;
      ACT_SET:               direct = (req_i.new_id == '0);
      ACT_LIST:              direct = (req_i.list_limit == '0);
      default:               direct = 1'b1;
    endcase
    unique case (act_q)
      ACT_LOOKUP, ACT_SET, ACT_CLEAR: fin = hit || at_end;
      ACT_LIST:                       fin = pv_q && (cur_used || at_end);
      default:                        fin = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          state_d = direct ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (fin) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (rsp_o.ready) begin
          state_d = last_q ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    act_d      = act_q;
    key_d      = key_q;
    nid_d      = nid_q;
    lim_d      = lim_q;
    idx_d      = idx_q;
    pv_d       = pv_q;
    pidx_d     = pidx_q;
    cnt_d      = cnt_q;
    free_vld_d = free_vld_q;
    free_idx_d = free_idx_q;
    used_d     = used_q;
    ok_d       = ok_q;
    ev_d       = ev_q;
    mac_d      = mac_q;
    idout_d    = idout_q;
    last_d     = last_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = pidx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          act_d      = req_i.action;
          key_d      = req_i.mac_key;
          nid_d      = req_i.new_id;
          lim_d      = req_i.list_limit;
          idx_d      = '0;
          pv_d       = 1'b0;
          cnt_d      = '0;
          free_vld_d = 1'b0;
          ok_d       = 1'b0;
          ev_d       = 1'b0;
          mac_d      = req_i.mac_key;
          idout_d    = '0;
          last_d     = 1'b1;
          if (req_i.action == ACT_CLEAR_ALL) begin
            used_d = '0;
            ok_d   = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (idx_q < IW'(Entries)) begin
          ram_re = 1'b1;
          pv_d   = 1'b1;
          pidx_d = idx_q[AW-1:0];
          idx_d  = idx_q + IW'(1);
        end else begin
          pv_d = 1'b0;
        end
        // lowest free slot seen so far, for set of a new key
        if (pv_q && !cur_used && !free_vld_q) begin
          free_vld_d = 1'b1;
          free_idx_d = pidx_q;
        end
        if (fin) begin
          pv_d    = 1'b0;
          ok_d    = 1'b0;
          ev_d    = 1'b0;
          mac_d   = key_q;
          idout_d = '0;
          last_d  = 1'b1;
          unique case (act_q)
            ACT_LOOKUP: begin
              if (hit) begin
                ok_d    = 1'b1;
                idout_d = rd_id;
              end
            end
            ACT_SET: begin
              if (hit) begin
                ram_we = 1'b1;
                ok_d   = 1'b1;
              end else if (free_vld_q || !cur_used) begin
                ram_we    = 1'b1;
                ram_waddr = free_vld_q ? free_idx_q : pidx_q;
                used_d[ram_waddr] = 1'b1;
                ok_d      = 1'b1;
              end
            end
            ACT_CLEAR: begin
              if (hit) begin
                used_d[pidx_q] = 1'b0;
                ok_d           = 1'b1;
              end
            end
            ACT_LIST: begin
              if (cur_used) begin
                ok_d    = 1'b1;
                ev_d    = 1'b1;
                mac_d   = rd_key;
                idout_d = rd_id;
                last_d  = (cnt_inc == lim_q) || !above;
                cnt_d   = cnt_inc;
                // restart the scan after this slot once the item is taken
                idx_d   = IW'(pidx_q) + IW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      used_q     <= '0;
      pv_q       <= 1'b0;
      idx_q      <= '0;
      cnt_q      <= '0;
      free_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      pv_q       <= pv_d;
      idx_q      <= idx_d;
      cnt_q      <= cnt_d;
      free_vld_q <= free_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    key_q      <= key_d;
    nid_q      <= nid_d;
    lim_q      <= lim_d;
    pidx_q     <= pidx_d;
    free_idx_q <= free_idx_d;
    ok_q       <= ok_d;
    ev_q       <= ev_d;
    mac_q      <= mac_d;
    idout_q    <= idout_d;
    last_q     <= last_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/mbt_ram.sv */
// ----------------------------------------------------------------------------
// mbt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mbt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* tb/mac_binding_table_top_tb.sv */
// ----------------------------------------------------------------------------
// mac_binding_table_top_tb
// Self-checking bench for the MAC binding table. A mirror of the table
// predicts the replies to every accepted request, and each reply is compared
// in order. Directed requests cover the corner cases. Random traffic over a
// small key pool keeps the table near full. Sender gaps and receiver stalls
// vary by phase, and one long receiver hold-off backs up the request side.
// ----------------------------------------------------------------------------
module mac_binding_table_top_tb;
  import mbt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES      = EntriesDef;
  localparam time         CLK_PERIOD   = 20ns;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned ITEMS_PHASE  = 120;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 2 * ENTRIES + 16;

  // codes outside the defined action set
  localparam logic [ACT_W-1:0] ACT_RSVD_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD_HI = 3'd7;

  localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] KEY_ALT  = 48'h5555_5555_5555;

  typedef struct packed {
    logic             ok;
    logic             entry_valid;
    logic [KEY_W-1:0] mac;
    logic [ID_W-1:0]  id;
    logic             last;
  } reply_t;

  // Mirror of the binding table plus the replies still owed by the block.
  class binding_mirror;
    logic [KEY_W-1:0] key_tbl [ENTRIES];
    logic [ID_W-1:0]  id_tbl  [ENTRIES];
    bit               used_tbl[ENTRIES];
    reply_t           pending_replies[$];
    int unsigned      mismatches;
    int unsigned      replies_seen;
    int unsigned      listed_entries;
    int unsigned      full_refusals;
    int unsigned      hits;
    int unsigned      action_count[8];

    function new();
      foreach (used_tbl[s]) used_tbl[s] = 1'b0;
    endfunction

    function int find_slot(logic [KEY_W-1:0] key);
      for (int s = 0; s < ENTRIES; s++)
        if (used_tbl[s] && key_tbl[s] == key) return s;
      return -1;
    endfunction

    function void owe(bit ok, bit ev, logic [KEY_W-1:0] mac, logic [ID_W-1:0] id, bit last);
      reply_t r;
      r.ok = ok;
      r.entry_valid = ev;
      r.mac = mac;
      r.id = id;
      r.last = last;
      pending_replies.push_back(r);
    endfunction

    function void note_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key,
                               logic [ID_W-1:0] nid, logic [LIM_W-1:0] lim);
      int s;
      int n;
      action_count[act]++;
      s = find_slot(key);
      case (act)
        ACT_LOOKUP: begin
          if (s < 0) owe(0, 0, key, '0, 1);
          else begin
            owe(1, 0, key, id_tbl[s], 1);
            hits++;
          end
        end
        ACT_SET: begin
          if (nid == '0) owe(0, 0, key, '0, 1);
          else begin
            if (s < 0)
              for (s = 0; s < ENTRIES && used_tbl[s]; s++) ;
            if (s >= ENTRIES) begin
              owe(0, 0, key, '0, 1);
              full_refusals++;
            end else begin
              used_tbl[s] = 1'b1;
              key_tbl[s] = key;
              id_tbl[s] = nid;
              owe(1, 0, key, '0, 1);
            end
          end
        end
        ACT_CLEAR: begin
          if (s < 0) owe(0, 0, key, '0, 1);
          else begin
            used_tbl[s] = 1'b0;
            owe(1, 0, key, '0, 1);
          end
        end
        ACT_CLEAR_ALL: begin
          foreach (used_tbl[i]) used_tbl[i] = 1'b0;
          owe(1, 0, key, '0, 1);
        end
        ACT_LIST: begin
          n = 0;
          for (int i = 0; i < ENTRIES && n < lim; i++)
            if (used_tbl[i]) begin
              owe(1, 1, key_tbl[i], id_tbl[i], 0);
              n++;
            end
          if (n == 0) owe(0, 0, key, '0, 1);
          else pending_replies[pending_replies.size()-1].last = 1'b1;
          listed_entries += n;
        end
        default: owe(0, 0, key, '0, 1);
      endcase
    endfunction

    function void check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(reply_t got);
      reply_t want;
      replies_seen++;
      if (pending_replies.size() == 0) begin
        $error("reply with nothing outstanding: mac 0x%0h id 0x%0h", got.mac, got.id);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      check_field("ok", want.ok, got.ok);
      check_field("entry_valid", want.entry_valid, got.entry_valid);
      check_field("mac_out", want.mac, got.mac);
      check_field("id_out", want.id, got.id);
      check_field("last", want.last, got.last);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mbt_req_if req_if ();
  mbt_rsp_if rsp_if ();

  mac_binding_table_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  binding_mirror    mirror;
  int unsigned      send_idle_pct;
  int unsigned      rsp_stall_pct;
  bit               hold_req;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        mirror.note_request(req_if.action, req_if.mac_key, req_if.new_id, req_if.list_limit);
      if (rsp_if.valid && rsp_if.ready)
        mirror.check_result({rsp_if.ok, rsp_if.entry_valid, rsp_if.mac_out,
                             rsp_if.id_out, rsp_if.last});
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("no handshake for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [KEY_W-1:0] random_key();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // pool mixes extremes, random keys and keys one bit away from a neighbor
  function automatic void refill_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      case ($urandom_range(0, 7))
        0: key_pool[i] = '0;
        1: key_pool[i] = KEY_ONES;
        2, 3: key_pool[i] = (i == 0) ? random_key()
                                     : key_pool[i-1] ^ (48'h1 << $urandom_range(0, KEY_W - 1));
        default: key_pool[i] = random_key();
      endcase
    end
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return random_key();
  endfunction

  task automatic send_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                              input logic [ID_W-1:0] nid, input logic [LIM_W-1:0] lim);
    int unsigned gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 24);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.mac_key    <= key;
    req_if.new_id     <= nid;
    req_if.list_limit <= lim;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic run_directed();
    send_request(ACT_LIST, KEY_ALT, 16'h0, 7'(ENTRIES));   // empty table lists nothing
    send_request(ACT_LOOKUP, '0, 16'h0, 7'd0);
    send_request(ACT_SET, '0, 16'h0, 7'd0);                 // zero id refused
    send_request(ACT_SET, '0, 16'h0001, 7'd0);
    send_request(ACT_SET, KEY_ONES, 16'hFFFF, 7'd127);
    send_request(ACT_LOOKUP, KEY_ONES, 16'h0, 7'd0);
    send_request(ACT_SET, '0, 16'h8000, 7'd0);              // rebind existing key
    send_request(ACT_LOOKUP, '0, 16'hFFFF, 7'd0);
    send_request(ACT_LIST, KEY_ONES, 16'h0, 7'd0);          // zero limit
    send_request(ACT_LIST, '0, 16'h0, 7'd1);
    send_request(ACT_LIST, KEY_ALT, 16'h0, 7'd127);
    send_request(ACT_CLEAR, '0, 16'h0, 7'd0);
    send_request(ACT_CLEAR, '0, 16'h0, 7'd0);               // already gone
    send_request(ACT_SET, KEY_ALT, 16'hAAAA, 7'd0);         // reuses freed low slot
    send_request(ACT_LIST, '0, 16'h0, 7'(ENTRIES + 1));
    send_request(ACT_RSVD_LO, KEY_ALT, 16'h1234, 7'd5);
    send_request(ACT_RSVD_HI, KEY_ONES, 16'hFFFF, 7'd127);
    send_request(ACT_LOOKUP, KEY_ALT, 16'h0, 7'd0);
    send_request(ACT_CLEAR_ALL, KEY_ONES, 16'hFFFF, 7'd127);
    send_request(ACT_LOOKUP, KEY_ONES, 16'h0, 7'd0);
    send_request(ACT_LIST, '0, 16'h0, 7'(ENTRIES));
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned      r;
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0]  nid;
    logic [LIM_W-1:0] lim;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 38) act = ACT_SET;
      else if (r < 62) act = ACT_LOOKUP;
      else if (r < 76) act = ACT_CLEAR;
      else if (r < 90) act = ACT_LIST;
      else if (r < 94) act = ACT_CLEAR_ALL;
      else act = 3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
      nid = ($urandom_range(0, 15) == 0) ? '0 : 16'($urandom);
      lim = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, ENTRIES + 2))
                                       : 7'($urandom_range(0, 127));
      if (act == ACT_CLEAR_ALL && $urandom_range(0, 1) == 0) refill_pool();
      send_request(act, pick_key(), nid, lim);
    end
  endtask

  initial begin : stimulus
    mirror = new();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.action = ACT_LOOKUP;
    req_if.mac_key = '0;
    req_if.new_id = '0;
    req_if.list_limit = '0;
    refill_pool();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          rsp_stall_pct = 0;
          hold_req = 1'b1;   // long back-pressure while requests keep coming
        end
        1: begin
          send_idle_pct = 64;
          rsp_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          rsp_stall_pct = 64;
        end
        default: begin
          send_idle_pct = 29;
          rsp_stall_pct = 29;
        end
      endcase
      run_random(ITEMS_PHASE);
    end
    req_if.valid <= 1'b0;

    // the last request is noted at the edge just passed; let the mirror catch up
    @(posedge clk_i);
    while (mirror.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run: lookup %0d (%0d hits), set %0d (%0d refused on full table), clear %0d,",
             mirror.action_count[ACT_LOOKUP], mirror.hits, mirror.action_count[ACT_SET],
             mirror.full_refusals, mirror.action_count[ACT_CLEAR]);
    $display("     clear-all %0d, list %0d (%0d entries listed), %0d replies checked",
             mirror.action_count[ACT_CLEAR_ALL], mirror.action_count[ACT_LIST],
             mirror.listed_entries, mirror.replies_seen);
    if (mirror.mismatches == 0 && mirror.pending_replies.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/mbt_pkg.sv
hw/rtl/mbt_req_if.sv
hw/rtl/mbt_rsp_if.sv
hw/rtl/mbt_ram.sv
hw/rtl/mac_binding_table_top.sv
tb/mac_binding_table_top_tb.sv
